/* rtl/qvr_pkg.sv */
`default_nettype none
package qvr_pkg;

  // Quaternion components are fixed at 16 bits, signed.
  localparam int QW = 16;
  // Vector and result width. Ports carry it through packed structs.
  localparam int VEC_WIDTH = 16;
  localparam int QUAT_FRAC_BITS_DEF = 14;

  // q*q products, and rotation matrix entries (sum of four products, or 2x a sum or difference)
  localparam int PROD_W = 2 * QW;
  localparam int CF_W   = PROD_W + 2;

  typedef logic signed [QW-1:0]        quat_t;
  typedef logic signed [VEC_WIDTH-1:0] vec_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [CF_W-1:0]      coef_t;

  typedef vec_t  [2:0] vec3_t;
  // row-major, entry row*3+col
  typedef coef_t [8:0] mat_t;

  typedef struct packed {
    quat_t q_scalar;
    quat_t q_i;
    quat_t q_j;
    quat_t q_k;
    vec_t  vec_x;
    vec_t  vec_y;
    vec_t  vec_z;
  } in_item_t;

  typedef struct packed {
    vec_t rot_x;
    vec_t rot_y;
    vec_t rot_z;
    logic clipped;
  } out_item_t;

  // matrix stage to multiply stage
  typedef struct packed {
    logic  vld;
    mat_t  mat;
    vec3_t vec;
  } coef_bus_t;

  function automatic coef_t ext_prod(input prod_t p);
    return {{(CF_W-PROD_W){p[PROD_W-1]}}, p};
  endfunction

  // Accumulator width: holds the exact sum of three products and the
  // rounding offset, with a sign bit left above the rounding shift.
  function automatic int acc_width(input int frac_bits);
    int sum_w;
    int rnd_w;
    sum_w = CF_W + VEC_WIDTH + 2;
    rnd_w = 2 * frac_bits + 2;
    return (sum_w > rnd_w) ? sum_w : rnd_w;
  endfunction

endpackage
`default_nettype wire

/* rtl/qvr_coef.sv */
`default_nettype none
module qvr_coef (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_vld,
  input  wire qvr_pkg::in_item_t   in_item,
  output qvr_pkg::coef_bus_t       bus
);

  // stage 1: the ten quaternion products
  logic            vld1_r;
  qvr_pkg::prod_t  ss_r, aa_r, bb_r, cc_r, ab_r, ac_r, bc_r, sa_r, sb_r, sc_r;
  qvr_pkg::prod_t  ss_nxt, aa_nxt, bb_nxt, cc_nxt, ab_nxt, ac_nxt, bc_nxt;
  qvr_pkg::prod_t  sa_nxt, sb_nxt, sc_nxt;
  qvr_pkg::vec3_t  vec1_r, vec1_nxt;

  // stage 2: rotation matrix
  qvr_pkg::coef_bus_t bus_r, bus_nxt;

  always_comb begin
    ss_nxt = $signed(in_item.q_scalar) * $signed(in_item.q_scalar);
    aa_nxt = $signed(in_item.q_i) * $signed(in_item.q_i);
    bb_nxt = $signed(in_item.q_j) * $signed(in_item.q_j);
    cc_nxt = $signed(in_item.q_k) * $signed(in_item.q_k);
    ab_nxt = $signed(in_item.q_i) * $signed(in_item.q_j);
    ac_nxt = $signed(in_item.q_i) * $signed(in_item.q_k);
    bc_nxt = $signed(in_item.q_j) * $signed(in_item.q_k);
    sa_nxt = $signed(in_item.q_scalar) * $signed(in_item.q_i);
    sb_nxt = $signed(in_item.q_scalar) * $signed(in_item.q_j);
    sc_nxt = $signed(in_item.q_scalar) * $signed(in_item.q_k);
    vec1_nxt[0] = in_item.vec_x;
    vec1_nxt[1] = in_item.vec_y;
    vec1_nxt[2] = in_item.vec_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
    end
    ss_r   <= ss_nxt;
    aa_r   <= aa_nxt;
    bb_r   <= bb_nxt;
    cc_r   <= cc_nxt;
    ab_r   <= ab_nxt;
    ac_r   <= ac_nxt;
    bc_r   <= bc_nxt;
    sa_r   <= sa_nxt;
    sb_r   <= sb_nxt;
    sc_r   <= sc_nxt;
    vec1_r <= vec1_nxt;
  end

  always_comb begin
    bus_nxt.vld    = vld1_r;
    bus_nxt.vec    = vec1_r;
    bus_nxt.mat[0] = qvr_pkg::ext_prod(ss_r) + qvr_pkg::ext_prod(aa_r)
                   - qvr_pkg::ext_prod(bb_r) - qvr_pkg::ext_prod(cc_r);
    bus_nxt.mat[1] = (qvr_pkg::ext_prod(ab_r) - qvr_pkg::ext_prod(sc_r)) <<< 1;
    bus_nxt.mat[2] = (qvr_pkg::ext_prod(ac_r) + qvr_pkg::ext_prod(sb_r)) <<< 1;
    bus_nxt.mat[3] = (qvr_pkg::ext_prod(ab_r) + qvr_pkg::ext_prod(sc_r)) <<< 1;
    bus_nxt.mat[4] = qvr_pkg::ext_prod(ss_r) - qvr_pkg::ext_prod(aa_r)
                   + qvr_pkg::ext_prod(bb_r) - qvr_pkg::ext_prod(cc_r);
    bus_nxt.mat[5] = (qvr_pkg::ext_prod(bc_r) - qvr_pkg::ext_prod(sa_r)) <<< 1;
    bus_nxt.mat[6] = (qvr_pkg::ext_prod(ac_r) - qvr_pkg::ext_prod(sb_r)) <<< 1;
    bus_nxt.mat[7] = (qvr_pkg::ext_prod(bc_r) + qvr_pkg::ext_prod(sa_r)) <<< 1;
    bus_nxt.mat[8] = qvr_pkg::ext_prod(ss_r) - qvr_pkg::ext_prod(aa_r)
                   - qvr_pkg::ext_prod(bb_r) + qvr_pkg::ext_prod(cc_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.vld <= 1'b0;
    end else begin
      bus_r.vld <= bus_nxt.vld;
    end
    bus_r.mat <= bus_nxt.mat;
    bus_r.vec <= bus_nxt.vec;
  end

  assign bus = bus_r;

endmodule
`default_nettype wire

/* rtl/qvr_mac.sv */
`default_nettype none
module qvr_mac #(
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire qvr_pkg::coef_bus_t    bus,
  output logic                       acc_vld,
  output logic [2:0][qvr_pkg::acc_width(QUAT_FRAC_BITS)-1:0] acc
);

  localparam int ACC_W = qvr_pkg::acc_width(QUAT_FRAC_BITS);
  localparam int MW    = qvr_pkg::CF_W + qvr_pkg::VEC_WIDTH;
  localparam logic signed [ACC_W-1:0] RND =
    {{(ACC_W-1){1'b0}}, 1'b1} << (2 * QUAT_FRAC_BITS - 1);

  // stage 3: nine matrix-by-vector products
  logic                 mvld_r;
  logic signed [MW-1:0] m_r   [9];
  logic signed [MW-1:0] m_nxt [9];

  // stage 4: row sums plus rounding offset
  logic                               avld_r;
  logic [2:0][ACC_W-1:0]              acc_r, acc_nxt;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m_nxt[r*3+c] = $signed(bus.mat[r*3+c]) * $signed(bus.vec[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvld_r <= 1'b0;
    end else begin
      mvld_r <= bus.vld;
    end
    for (int i = 0; i < 9; i++) begin
      m_r[i] <= m_nxt[i];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc_nxt[r] = ACC_W'(m_r[r*3]) + ACC_W'(m_r[r*3+1]) + ACC_W'(m_r[r*3+2]) + RND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avld_r <= 1'b0;
    end else begin
      avld_r <= mvld_r;
    end
    acc_r <= acc_nxt;
  end

  assign acc_vld = avld_r;
  assign acc     = acc_r;

endmodule
`default_nettype wire

/* rtl/qvr_round.sv */
`default_nettype none
module qvr_round #(
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  acc_vld,
  input  wire logic [2:0][qvr_pkg::acc_width(QUAT_FRAC_BITS)-1:0] acc,
  output logic                       out_vld,
  output qvr_pkg::out_item_t         out_item
);

  localparam int ACC_W = qvr_pkg::acc_width(QUAT_FRAC_BITS);
  localparam int SH    = 2 * QUAT_FRAC_BITS;
  localparam int VW    = qvr_pkg::VEC_WIDTH;
  localparam logic signed [ACC_W-1:0] MAXV = {{(ACC_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] MINV = ~MAXV;

  logic signed [ACC_W-1:0] shf [3];
  qvr_pkg::vec3_t          res;
  logic [2:0]              sat;

  logic                    vld_r;
  qvr_pkg::out_item_t      item_r, item_nxt;

  // offset already added upstream: floor shift gives round to nearest
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shf[r] = $signed(acc[r]) >>> SH;
      if (shf[r] > MAXV) begin
        res[r] = MAXV[VW-1:0];
        sat[r] = 1'b1;
      end else if (shf[r] < MINV) begin
        res[r] = MINV[VW-1:0];
        sat[r] = 1'b1;
      end else begin
        res[r] = shf[r][VW-1:0];
        sat[r] = 1'b0;
      end
    end
    item_nxt.rot_x   = res[0];
    item_nxt.rot_y   = res[1];
    item_nxt.rot_z   = res[2];
    item_nxt.clipped = |sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= acc_vld;
    end
    item_r <= item_nxt;
  end

  assign out_vld  = vld_r;
  assign out_item = item_r;

endmodule
`default_nettype wire

/* rtl/quaternion_vector_rotation_top.sv */
`default_nettype none
// Quaternion vector rotation: r = q * (0,v) * conj(q), exact, then rounded
// to nearest and saturated to the vector width.
//
// Input channel: drive in_data (q in signed Q2.14, v as signed integers) and
// raise start. A transaction is taken at every rising edge with start high
// and busy low. busy is low whenever rst_n is high, so one transaction can
// enter every cycle, back to back.
// Result channel: out_valid is high for exactly one cycle with out_data
// (rot_x/y/z and clipped). The receiver cannot stall; results are simply
// presented and must be captured in that cycle.
// Throughput: 1 transaction per cycle while rst_n is high, through five
// register stages in order (quaternion products, matrix entries,
// matrix-vector products, row sums, round/saturate), each fully
// pipelined.
// Reset: synchronous, active low. All stage valid bits clear, so no result
// comes out for anything in flight; busy is high while reset is held.
// No normalization: a non-unit q scales the result by |q|^2.
module quaternion_vector_rotation_top #(
  parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire qvr_pkg::in_item_t   in_data,
  output logic                     out_valid,
  output qvr_pkg::out_item_t       out_data
);

  localparam int LATENCY = 5;
  localparam int ACC_W   = qvr_pkg::acc_width(QUAT_FRAC_BITS);

  logic                  accept;
  qvr_pkg::coef_bus_t    coef_bus;
  logic                  acc_vld;
  logic [2:0][ACC_W-1:0] acc;

  // every stage advances each cycle; only reset holds off new transactions
  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  // stages 1-2: ten q products, then the rotation matrix
  qvr_coef u_coef (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (accept),
    .in_item (in_data),
    .bus     (coef_bus)
  );

  // stages 3-4: matrix times vector, row sums with rounding offset
  qvr_mac #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .bus     (coef_bus),
    .acc_vld (acc_vld),
    .acc     (acc)
  );

  // stage 5: drop fraction bits, clamp, flag
  qvr_round #(
    .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
  ) u_round (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc_vld  (acc_vld),
    .acc      (acc),
    .out_vld  (out_valid),
    .out_item (out_data)
  );

  // one result per accepted transaction, fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(accept, LATENCY))
    else $error("result strobe does not match accepted transaction");

  // a clip flag means some component sits at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.clipped) |->
      (out_data.rot_x == {1'b0, {(qvr_pkg::VEC_WIDTH-1){1'b1}}} ||
       out_data.rot_x == {1'b1, {(qvr_pkg::VEC_WIDTH-1){1'b0}}} ||
       out_data.rot_y == {1'b0, {(qvr_pkg::VEC_WIDTH-1){1'b1}}} ||
       out_data.rot_y == {1'b1, {(qvr_pkg::VEC_WIDTH-1){1'b0}}} ||
       out_data.rot_z == {1'b0, {(qvr_pkg::VEC_WIDTH-1){1'b1}}} ||
       out_data.rot_z == {1'b1, {(qvr_pkg::VEC_WIDTH-1){1'b0}}}))
    else $error("clipped set with no component at a limit");

  // zero quaternion gives a zero, unclipped result
  a_zero_q: assert property (@(posedge clk) disable iff (!rst_n)
    $past(accept && in_data.q_scalar == '0 && in_data.q_i == '0 &&
          in_data.q_j == '0 && in_data.q_k == '0, LATENCY) |->
      (out_data.rot_x == '0 && out_data.rot_y == '0 &&
       out_data.rot_z == '0 && !out_data.clipped))
    else $error("zero quaternion gave a nonzero result");

endmodule
`default_nettype wire

/* tb/qvr_rotation_monitor.sv */
`timescale 1ns / 1ps

// Watches both channels, predicts each rotation, compares results in order.
module qvr_rotation_monitor (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire qvr_pkg::in_item_t  in_data,
  input  wire logic               out_valid,
  input  wire qvr_pkg::out_item_t out_data,
  output int                      mismatches,
  output int                      outstanding
);

  localparam int     RND_SHIFT = 2 * qvr_pkg::QUAT_FRAC_BITS_DEF;
  localparam longint VEC_MAX   = (longint'(1) <<< (qvr_pkg::VEC_WIDTH - 1)) - 1;
  localparam longint VEC_MIN   = -VEC_MAX - 1;
  localparam int     MAX_PRINT = 50;

  qvr_pkg::out_item_t rot_fifo[$];
  int                 result_idx;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    result_idx  = 0;
  end

  // Exact rotation matrix times v; every product fits easily in 64 bits.
  function automatic qvr_pkg::out_item_t rotate_vec(input qvr_pkg::in_item_t it);
    longint             s, a, b, c, acc;
    longint             m [9];
    longint             v [3];
    longint             comp [3];
    qvr_pkg::out_item_t r;
    s = $signed(it.q_scalar);
    a = $signed(it.q_i);
    b = $signed(it.q_j);
    c = $signed(it.q_k);
    v[0] = $signed(it.vec_x);
    v[1] = $signed(it.vec_y);
    v[2] = $signed(it.vec_z);
    m[0] = s*s + a*a - b*b - c*c;
    m[1] = 2 * (a*b - s*c);
    m[2] = 2 * (a*c + s*b);
    m[3] = 2 * (a*b + s*c);
    m[4] = s*s - a*a + b*b - c*c;
    m[5] = 2 * (b*c - s*a);
    m[6] = 2 * (a*c - s*b);
    m[7] = 2 * (b*c + s*a);
    m[8] = s*s - a*a - b*b + c*c;
    r.clipped = 1'b0;
    for (int row = 0; row < 3; row++) begin
      acc = m[3*row] * v[0] + m[3*row+1] * v[1] + m[3*row+2] * v[2];
      // round half up, then floor shift
      acc = (acc + (longint'(1) <<< (RND_SHIFT - 1))) >>> RND_SHIFT;
      if (acc > VEC_MAX) begin
        acc = VEC_MAX;
        r.clipped = 1'b1;
      end else if (acc < VEC_MIN) begin
        acc = VEC_MIN;
        r.clipped = 1'b1;
      end
      comp[row] = acc;
    end
    r.rot_x = qvr_pkg::vec_t'(comp[0]);
    r.rot_y = qvr_pkg::vec_t'(comp[1]);
    r.rot_z = qvr_pkg::vec_t'(comp[2]);
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    if (mismatches < MAX_PRINT)
      $display("MISMATCH result %0d: %s got %0d expected %0d",
               result_idx, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    qvr_pkg::out_item_t want;
    if (out_valid) begin
      if (rot_fifo.size() == 0) begin
        report("rot_x with no transaction pending", $signed(out_data.rot_x), 0);
      end else begin
        want = rot_fifo.pop_front();
        if (out_data.rot_x !== want.rot_x)
          report("rot_x", $signed(out_data.rot_x), $signed(want.rot_x));
        if (out_data.rot_y !== want.rot_y)
          report("rot_y", $signed(out_data.rot_y), $signed(want.rot_y));
        if (out_data.rot_z !== want.rot_z)
          report("rot_z", $signed(out_data.rot_z), $signed(want.rot_z));
        if (out_data.clipped !== want.clipped)
          report("clipped", out_data.clipped, want.clipped);
      end
      result_idx++;
    end
    if (rst_n && start && !busy)
      rot_fifo.push_back(rotate_vec(in_data));
    outstanding <= rot_fifo.size();
  end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps

// Drives quaternion/vector transactions into the rotation pipeline and
// gives the verdict. All prediction and comparison lives in the monitor.
module tb;

  localparam int RAND_ITEMS = 950;
  // final stretch of the run with start held high every cycle
  localparam int QUIET_TAIL = 150;
  // watchdog limit; far beyond what the slowest run of transactions needs
  localparam int LIMIT      = 200000;
  // pipeline is 5 deep; wait well past it for any stray result
  localparam int DRAIN      = 20;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  qvr_pkg::in_item_t  in_data;
  logic               out_valid;
  qvr_pkg::out_item_t out_data;
  int                 mismatches;
  int                 outstanding;
  int                 cycles;

  quaternion_vector_rotation_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  qvr_rotation_monitor u_mon (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Watchdog: a hung pipeline or a lost result ends here.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("quaternion_vector_rotation_top verification failed");
      $finish;
    end
  end

  function automatic qvr_pkg::in_item_t mk(input int s, input int a, input int b,
                                           input int c, input int x, input int y,
                                           input int z);
    qvr_pkg::in_item_t it;
    it.q_scalar = qvr_pkg::quat_t'(s);
    it.q_i      = qvr_pkg::quat_t'(a);
    it.q_j      = qvr_pkg::quat_t'(b);
    it.q_k      = qvr_pkg::quat_t'(c);
    it.vec_x    = qvr_pkg::vec_t'(x);
    it.vec_y    = qvr_pkg::vec_t'(y);
    it.vec_z    = qvr_pkg::vec_t'(z);
    return it;
  endfunction

  // Quaternion component within about +/-1.0.
  function automatic qvr_pkg::quat_t unit_span();
    return qvr_pkg::quat_t'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic qvr_pkg::vec_t extreme_val();
    case ($urandom_range(0, 4))
      0: return qvr_pkg::vec_t'(32767);
      1: return qvr_pkg::vec_t'(-32768);
      2: return qvr_pkg::vec_t'(0);
      3: return qvr_pkg::vec_t'(1);
      default: return qvr_pkg::vec_t'(-1);
    endcase
  endfunction

  // Present one transaction and hold it until the edge that takes it.
  // busy is sampled before the edge's updates, like the block sees it.
  task automatic send_item(input qvr_pkg::in_item_t it);
    in_data <= it;
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Gap on the input side; the bus carries junk that must be ignored.
  task automatic idle_burst(input int n);
    logic [127:0] junk;
    junk = {$urandom, $urandom, $urandom, $urandom};
    start   <= 1'b0;
    in_data <= junk[$bits(qvr_pkg::in_item_t)-1:0];
    repeat (n) @(posedge clk);
  endtask

  initial begin
    qvr_pkg::in_item_t it;
    logic [127:0]      junk;
    int                idle_pct;
    rst_n   = 1'b0;
    start   = 1'b0;
    in_data = '0;
    idle_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed transactions ----
    // zero quaternion: everything collapses to 0, no clip
    send_item(mk(0, 0, 0, 0, 32767, -32768, 1));
    // identity with the vector extremes, and with a zero vector
    send_item(mk(16384, 0, 0, 0, 32767, -32768, -1));
    send_item(mk(16384, 0, 0, 0, 0, 0, 0));
    // 90 degrees about z
    send_item(mk(11585, 0, 0, 11585, 1000, 0, 0));
    // 180 degrees about each axis
    send_item(mk(0, 16384, 0, 0, 100, 200, 300));
    send_item(mk(0, 0, 16384, 0, -100, 200, -300));
    send_item(mk(0, 0, 0, 16384, 1, 2, 3));
    // q = -1 rotates like +1
    send_item(mk(-16384, 0, 0, 0, 1, 2, 3));
    // |q|^2 = 1/4: exact half-way ties and quarter fractions
    send_item(mk(8192, 0, 0, 0, 2, -2, 6));
    send_item(mk(8192, 0, 0, 0, 1, -1, 3));
    // |q|^2 = 4: one component clips high, one lands on the low limit exactly
    send_item(mk(-32768, 0, 0, 0, 16384, -8192, 8191));
    // full-scale quaternions against full-scale vectors, heavy saturation
    send_item(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767));
    send_item(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
    send_item(mk(-32768, 32767, -32768, 32767, 32767, -32768, 32767));
    send_item(mk(32767, -32768, 32767, -32768, -32768, 32767, -32768));
    // non-unit, |q|^2 = 2
    send_item(mk(0, 16384, 16384, 0, 10000, 20000, -20000));
    // tiny quaternions: results round to near zero
    send_item(mk(-1, -1, -1, -1, 32767, 32767, 32767));
    send_item(mk(1, 0, 0, 0, 32767, -32768, 32767));
    // near identity at the vector limits
    send_item(mk(16383, 1, -1, 1, -32768, 32767, -32768));
    // 120 degrees about (1,1,1): cyclic permutation of the axes
    send_item(mk(8192, 8192, 8192, 8192, 1, 2, 3));

    // ---- random transactions ----
    for (int n = 0; n < RAND_ITEMS; n++) begin
      // idle density changes in blocks, including blocks with none at all
      if (n % 64 == 0) begin
        case ($urandom_range(0, 3))
          0: idle_pct = 0;
          1: idle_pct = 10;
          2: idle_pct = 30;
          default: idle_pct = 60;
        endcase
      end
      if (n >= RAND_ITEMS - QUIET_TAIL)
        idle_pct = 0;
      if (int'($urandom_range(0, 99)) < idle_pct)
        idle_burst($urandom_range(1, 10));

      junk = {$urandom, $urandom, $urandom, $urandom};
      it = junk[$bits(qvr_pkg::in_item_t)-1:0];
      case ($urandom_range(0, 3))
        0: ; // every bit random
        1: begin
          // rotation-like quaternion, full vector range
          it.q_scalar = unit_span();
          it.q_i      = unit_span();
          it.q_j      = unit_span();
          it.q_k      = unit_span();
        end
        2: begin
          // sparse quaternion, small vector: fractions and rounding
          it.q_scalar = $urandom_range(0, 1) ? unit_span() : qvr_pkg::quat_t'(0);
          it.q_i      = $urandom_range(0, 1) ? unit_span() : qvr_pkg::quat_t'(0);
          it.q_j      = $urandom_range(0, 1) ? unit_span() : qvr_pkg::quat_t'(0);
          it.q_k      = $urandom_range(0, 1) ? unit_span() : qvr_pkg::quat_t'(0);
          it.vec_x    = qvr_pkg::vec_t'(int'($urandom_range(0, 2000)) - 1000);
          it.vec_y    = qvr_pkg::vec_t'(int'($urandom_range(0, 2000)) - 1000);
          it.vec_z    = qvr_pkg::vec_t'(int'($urandom_range(0, 2000)) - 1000);
        end
        default: begin
          // random quaternion against vector corner values
          it.vec_x = extreme_val();
          it.vec_y = extreme_val();
          it.vec_z = extreme_val();
        end
      endcase
      send_item(it);
    end
    start <= 1'b0;

    // wait for every predicted result, then for any stray one
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0)
      $display("quaternion_vector_rotation_top verification clean");
    else
      $display("quaternion_vector_rotation_top verification failed");
    $finish;
  end

endmodule
